// ===== hdl/vfme_pkg.sv =====
// shared types, constants and corner tables for the voxel face mesh emitter
// depends on nothing; imported by the controller, datapath and top level
package vfme_pkg;

  localparam int unsigned NUM_FACES   = 6;
  localparam int unsigned NUM_CORNERS = 6;
  localparam int unsigned FACE_W      = 3;
  localparam int unsigned CORNER_W    = 3;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned LAYER_W     = 2;
  localparam int unsigned SHADE_W     = 8;

  typedef logic [NUM_FACES-1:0] face_mask_t;
  typedef logic [FACE_W-1:0]    face_t;
  typedef logic [CORNER_W-1:0]  corner_t;
  typedef logic [KIND_W-1:0]    kind_t;
  typedef logic [LAYER_W-1:0]   layer_t;
  typedef logic [SHADE_W-1:0]   shade_t;

  localparam kind_t   KIND_AIR    = 2'd0;
  localparam corner_t CORNER_LAST = corner_t'(NUM_CORNERS - 1);

  // corner offsets as {x, y, z}, faces +z,-z,+x,-x,+y,-y
  localparam logic [2:0] FACE_CORNER [NUM_FACES][NUM_CORNERS] = '{
    '{3'b001, 3'b101, 3'b111, 3'b001, 3'b111, 3'b011},
    '{3'b100, 3'b000, 3'b010, 3'b100, 3'b010, 3'b110},
    '{3'b101, 3'b100, 3'b110, 3'b101, 3'b110, 3'b111},
    '{3'b000, 3'b001, 3'b011, 3'b000, 3'b011, 3'b010},
    '{3'b011, 3'b111, 3'b110, 3'b011, 3'b110, 3'b010},
    '{3'b000, 3'b100, 3'b101, 3'b000, 3'b101, 3'b001}
  };

  localparam logic CORNER_U [NUM_CORNERS] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
  localparam logic CORNER_V [NUM_CORNERS] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};

  // max(0.25, n . normalize(0.5, 1.0, 0.4)) in Q0.8
  localparam shade_t FACE_BRIGHT_Q8 [NUM_FACES] = '{
    8'd86, 8'd64, 8'd108, 8'd64, 8'd216, 8'd64
  };

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } vfme_state_t;

  typedef struct packed {
    logic load;
    logic emit;
  } vfme_cmd_t;

  typedef struct packed {
    logic has_work;
    logic out_free;
    logic last;
  } vfme_status_t;

  // one-hot face bit to face number
  function automatic face_t face_encode(input face_mask_t onehot);
    face_t idx;
    idx = '0;
    for (int i = 0; i < NUM_FACES; i++) begin
      if (onehot[i]) begin
        idx = face_t'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== hdl/voxel_face_mesh_emitter_core.sv =====
// an item is taken in idle, then the emit state builds each vertex into the output register,
// one vertex per cycle while out_stall is low, walking exposed faces in +z,-z,+x,-x,+y,-y order
// six vertices per exposed face; an air or fully hidden voxel is taken without leaving idle;
// the output register lets a new item in while the last vertex still waits; synchronous
// active-low reset clears the fsm, the face mask, the corner counter and valid
module voxel_face_mesh_emitter_core
  import vfme_pkg::*;
#(
  parameter int unsigned COORD_BITS = 20
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_block_x,
  input  logic signed [COORD_BITS-1:0] in_block_y,
  input  logic signed [COORD_BITS-1:0] in_block_z,
  input  kind_t                        in_block_kind,
  input  face_mask_t                   in_exposed_mask,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS:0]   out_pos_x,
  output logic signed [COORD_BITS:0]   out_pos_y,
  output logic signed [COORD_BITS:0]   out_pos_z,
  output logic                         out_tex_u,
  output logic                         out_tex_v,
  output layer_t                       out_tex_layer,
  output shade_t                       out_shade,
  output face_t                        out_face_index,
  output logic                         out_last_vertex
);

  vfme_cmd_t    cmd;
  vfme_status_t status;

  vfme_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  vfme_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_block_x      (in_block_x),
    .in_block_y      (in_block_y),
    .in_block_z      (in_block_z),
    .in_block_kind   (in_block_kind),
    .in_exposed_mask (in_exposed_mask),
    .cmd             (cmd),
    .status          (status),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_pos_x       (out_pos_x),
    .out_pos_y       (out_pos_y),
    .out_pos_z       (out_pos_z),
    .out_tex_u       (out_tex_u),
    .out_tex_v       (out_tex_v),
    .out_tex_layer   (out_tex_layer),
    .out_shade       (out_shade),
    .out_face_index  (out_face_index),
    .out_last_vertex (out_last_vertex)
  );

endmodule

// ===== hdl/vfme_ctrl.sv =====
// controller state machine: takes an item, then steps the datapath vertex by vertex
// depends on vfme_pkg
module vfme_ctrl
  import vfme_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  vfme_status_t status,
  output vfme_cmd_t    cmd
);

  vfme_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          // air or fully hidden voxels produce nothing
          if (status.has_work) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_no_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !cmd.emit)
    else $error("vertex emitted while idle");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && status.last |=> state_r == ST_IDLE)
    else $error("controller stayed busy after last vertex");

  a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> state_r == ST_IDLE && !cmd.emit)
    else $error("item loaded while emitting");
`endif

endmodule

// ===== hdl/vfme_dp.sv =====
// datapath: voxel registers, face/corner walk, vertex build and output register
// depends on vfme_pkg
module vfme_dp
  import vfme_pkg::*;
#(
  parameter int unsigned COORD_BITS = 20
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic signed [COORD_BITS-1:0] in_block_x,
  input  logic signed [COORD_BITS-1:0] in_block_y,
  input  logic signed [COORD_BITS-1:0] in_block_z,
  input  kind_t                        in_block_kind,
  input  face_mask_t                   in_exposed_mask,
  input  vfme_cmd_t                    cmd,
  output vfme_status_t                 status,
  input  logic                         out_stall,
  output logic                         out_valid,
  output logic signed [COORD_BITS:0]   out_pos_x,
  output logic signed [COORD_BITS:0]   out_pos_y,
  output logic signed [COORD_BITS:0]   out_pos_z,
  output logic                         out_tex_u,
  output logic                         out_tex_v,
  output layer_t                       out_tex_layer,
  output shade_t                       out_shade,
  output face_t                        out_face_index,
  output logic                         out_last_vertex
);

  logic signed [COORD_BITS-1:0] bx_r, by_r, bz_r;
  layer_t                       layer_r;
  face_mask_t                   mask_r;
  corner_t                      corner_r;
  logic                         out_valid_r;
  logic signed [COORD_BITS:0]   pos_x_r, pos_y_r, pos_z_r;
  logic                         tex_u_r, tex_v_r, last_r;
  layer_t                       tex_layer_r;
  shade_t                       shade_r;
  face_t                        face_r;

  face_mask_t low_bit;
  face_mask_t remain;
  face_t      face;
  logic [2:0] offs;
  logic       corner_done;

  // lowest pending face is the one being walked
  assign low_bit     = mask_r & (~mask_r + face_mask_t'(1));
  assign remain      = mask_r & ~low_bit;
  assign face        = face_encode(low_bit);
  assign offs        = FACE_CORNER[face][corner_r];
  assign corner_done = (corner_r == CORNER_LAST);

  assign status.has_work = (in_block_kind != KIND_AIR) && (in_exposed_mask != '0);
  assign status.out_free = !out_valid_r || !out_stall;
  assign status.last     = corner_done && (remain == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      corner_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        mask_r   <= in_exposed_mask;
        corner_r <= '0;
      end else if (cmd.emit) begin
        if (corner_done) begin
          corner_r <= '0;
          mask_r   <= remain;
        end else begin
          corner_r <= corner_r + corner_t'(1);
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bx_r    <= in_block_x;
      by_r    <= in_block_y;
      bz_r    <= in_block_z;
      layer_r <= layer_t'(in_block_kind - kind_t'(1));
    end
    if (cmd.emit) begin
      // sum is one bit wider so the edge of the range never wraps
      pos_x_r     <= {bx_r[COORD_BITS-1], bx_r} + {{COORD_BITS{1'b0}}, offs[2]};
      pos_y_r     <= {by_r[COORD_BITS-1], by_r} + {{COORD_BITS{1'b0}}, offs[1]};
      pos_z_r     <= {bz_r[COORD_BITS-1], bz_r} + {{COORD_BITS{1'b0}}, offs[0]};
      tex_u_r     <= CORNER_U[corner_r];
      tex_v_r     <= CORNER_V[corner_r];
      tex_layer_r <= layer_r;
      shade_r     <= FACE_BRIGHT_Q8[face];
      face_r      <= face;
      last_r      <= status.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pos_x       = pos_x_r;
  assign out_pos_y       = pos_y_r;
  assign out_pos_z       = pos_z_r;
  assign out_tex_u       = tex_u_r;
  assign out_tex_v       = tex_v_r;
  assign out_tex_layer   = tex_layer_r;
  assign out_shade       = shade_r;
  assign out_face_index  = face_r;
  assign out_last_vertex = last_r;

`ifndef SYNTHESIS
  a_emit_has_face: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> mask_r != '0)
    else $error("vertex emitted with no pending face");

  a_last_clears_mask: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && status.last |=> mask_r == '0)
    else $error("faces left after last vertex");

  a_corner_range: assert property (@(posedge clk) disable iff (!rst_n)
    corner_r <= CORNER_LAST)
    else $error("corner counter out of range");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !cmd.emit)
    else $error("output register overwritten while stalled");
`endif

endmodule

// ===== test/voxel_face_mesh_emitter_core_tb.sv =====
// self-checking testbench for voxel_face_mesh_emitter_core: voxels in, face vertices out
// depends on vfme_pkg and the core; prediction uses its own corner and shade tables
module voxel_face_mesh_emitter_core_tb;
  import vfme_pkg::*;

  localparam int COORD_W      = 20;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int TOTAL_VOXELS = 170;

  localparam kind_t KIND_GRASS = 2'd1;
  localparam kind_t KIND_DIRT  = 2'd2;
  localparam kind_t KIND_STONE = 2'd3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [COORD_W:0]   vpos_t;

  typedef struct packed {
    coord_t     x;
    coord_t     y;
    coord_t     z;
    kind_t      kind;
    face_mask_t mask;
    logic       drain_first;
  } voxel_t;

  typedef struct packed {
    vpos_t  pos_x;
    vpos_t  pos_y;
    vpos_t  pos_z;
    logic   tex_u;
    logic   tex_v;
    layer_t layer;
    shade_t shade;
    face_t  face;
    logic   last;
  } vertex_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  // two triangles per face, corners given as {dx, dy, dz}; faces +z,-z,+x,-x,+y,-y
  localparam logic [2:0] QUAD_OFFSET [6][6] = '{
    '{3'b001, 3'b101, 3'b111, 3'b001, 3'b111, 3'b011},
    '{3'b100, 3'b000, 3'b010, 3'b100, 3'b010, 3'b110},
    '{3'b101, 3'b100, 3'b110, 3'b101, 3'b110, 3'b111},
    '{3'b000, 3'b001, 3'b011, 3'b000, 3'b011, 3'b010},
    '{3'b011, 3'b111, 3'b110, 3'b011, 3'b110, 3'b010},
    '{3'b000, 3'b100, 3'b101, 3'b000, 3'b101, 3'b001}
  };
  localparam logic [5:0] QUAD_U = 6'b010110;  // bit k is corner k
  localparam logic [5:0] QUAD_V = 6'b110100;
  // lambert term against the fixed sun, floored at a quarter
  localparam shade_t FACE_BRIGHTNESS [6] = '{8'd86, 8'd64, 8'd108, 8'd64, 8'd216, 8'd64};

  logic clk = 1'b1;
  logic rst_n = 1'b0;

  logic       in_valid = 1'b0;
  logic       in_stall;
  coord_t     in_block_x = '0;
  coord_t     in_block_y = '0;
  coord_t     in_block_z = '0;
  kind_t      in_block_kind = KIND_AIR;
  face_mask_t in_exposed_mask = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  vpos_t      out_pos_x;
  vpos_t      out_pos_y;
  vpos_t      out_pos_z;
  logic       out_tex_u;
  logic       out_tex_v;
  layer_t     out_tex_layer;
  shade_t     out_shade;
  face_t      out_face_index;
  logic       out_last_vertex;

  voxel_t  pending_voxels[$];
  vertex_t expected_vertices[$];
  voxel_t  voxel_on_bus = '0;

  int mismatches = 0;
  int vertices_seen = 0;
  int cycle_count = 0;
  int burst_left = 8;
  int gap_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int stall_left = 30;
  int stall_phase = 0;

  voxel_face_mesh_emitter_core #(
    .COORD_BITS(COORD_W)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_block_x     (in_block_x),
    .in_block_y     (in_block_y),
    .in_block_z     (in_block_z),
    .in_block_kind  (in_block_kind),
    .in_exposed_mask(in_exposed_mask),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pos_x      (out_pos_x),
    .out_pos_y      (out_pos_y),
    .out_pos_z      (out_pos_z),
    .out_tex_u      (out_tex_u),
    .out_tex_v      (out_tex_v),
    .out_tex_layer  (out_tex_layer),
    .out_shade      (out_shade),
    .out_face_index (out_face_index),
    .out_last_vertex(out_last_vertex)
  );

  always begin
    #2 clk = 1'b0;
    #2 clk = 1'b1;
  end

  // every vertex a voxel yields, in emission order
  task automatic predict_vertices(input voxel_t vox);
    vertex_t vtx;
    int      total;
    int      made;
    total = $countones(vox.mask) * 6;
    made = 0;
    if (vox.kind != KIND_AIR) begin
      for (int f = 0; f < 6; f++) begin
        if (vox.mask[f]) begin
          for (int k = 0; k < 6; k++) begin
            // one bit wider so the top corner never wraps
            vtx.pos_x = {vox.x[COORD_W-1], vox.x} + vpos_t'(QUAD_OFFSET[f][k][2]);
            vtx.pos_y = {vox.y[COORD_W-1], vox.y} + vpos_t'(QUAD_OFFSET[f][k][1]);
            vtx.pos_z = {vox.z[COORD_W-1], vox.z} + vpos_t'(QUAD_OFFSET[f][k][0]);
            vtx.tex_u = QUAD_U[k];
            vtx.tex_v = QUAD_V[k];
            vtx.layer = layer_t'(vox.kind - KIND_GRASS);
            vtx.shade = FACE_BRIGHTNESS[f];
            vtx.face  = face_t'(f);
            vtx.last  = (made == total - 1);
            expected_vertices.push_back(vtx);
            made++;
          end
        end
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("error at cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("vertex %0d %s got 0x%0h want 0x%0h",
                                vertices_seen, name, got, want));
    end
  endtask

  function automatic coord_t pick_coord();
    case ($urandom_range(0, 7))
      0: pick_coord = {1'b0, {(COORD_W-1){1'b1}}};
      1: pick_coord = {1'b1, {(COORD_W-1){1'b0}}};
      2: pick_coord = '1;
      3: pick_coord = coord_t'($urandom_range(0, 15)) - coord_t'(8);
      default: pick_coord = coord_t'($urandom);
    endcase
  endfunction

  function automatic voxel_t make_voxel(input coord_t x, input coord_t y, input coord_t z,
                                        input kind_t kind, input face_mask_t mask,
                                        input logic drain_first);
    make_voxel = '{x: x, y: y, z: z, kind: kind, mask: mask, drain_first: drain_first};
  endfunction

  // sender: bursts of items with random gaps, fed from pending_voxels
  always @(posedge clk) begin : sender
    voxel_t vox;
    logic   offer;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_vertices(voxel_on_bus);
      end
      offer = 1'b0;
      if (in_valid && in_stall) begin
        offer = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (pending_voxels.size() > 0 &&
                   !(pending_voxels[0].drain_first && expected_vertices.size() > 0)) begin
        vox = pending_voxels.pop_front();
        voxel_on_bus    <= vox;
        in_block_x      <= vox.x;
        in_block_y      <= vox.y;
        in_block_z      <= vox.z;
        in_block_kind   <= vox.kind;
        in_exposed_mask <= vox.mask;
        offer = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
        end
      end
      in_valid <= offer;
    end
  end

  // receiver: stall pattern switches between modes, checks every accepted item
  always @(posedge clk) begin : receiver
    vertex_t got_vtx;
    vertex_t want_vtx;
    if (rst_n && out_valid && !out_stall) begin
      got_vtx = {out_pos_x, out_pos_y, out_pos_z, out_tex_u, out_tex_v, out_tex_layer,
                 out_shade, out_face_index, out_last_vertex};
      if (expected_vertices.size() == 0) begin
        report_mismatch($sformatf("vertex %0d arrived with nothing pending", vertices_seen));
      end else begin
        want_vtx = expected_vertices.pop_front();
        check_field("pos_x", 32'(got_vtx.pos_x), 32'(want_vtx.pos_x));
        check_field("pos_y", 32'(got_vtx.pos_y), 32'(want_vtx.pos_y));
        check_field("pos_z", 32'(got_vtx.pos_z), 32'(want_vtx.pos_z));
        check_field("tex_u", 32'(got_vtx.tex_u), 32'(want_vtx.tex_u));
        check_field("tex_v", 32'(got_vtx.tex_v), 32'(want_vtx.tex_v));
        check_field("tex_layer", 32'(got_vtx.layer), 32'(want_vtx.layer));
        check_field("shade", 32'(got_vtx.shade), 32'(want_vtx.shade));
        check_field("face_index", 32'(got_vtx.face), 32'(want_vtx.face));
        check_field("last_vertex", 32'(got_vtx.last), 32'(want_vtx.last));
      end
      vertices_seen++;
    end
    if (stall_left > 0) begin
      stall_left--;
    end else begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(20, 200);
    end
    stall_phase++;
    case (stall_mode)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
      STALL_PERIODIC: out_stall <= ((stall_phase % 9) < 4);
      default:        out_stall <= 1'b0;
    endcase
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout with %0d vertices still pending", expected_vertices.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    voxel_t     vox;
    int         useful;
    coord_t     cmax;
    coord_t     cmin;
    face_mask_t all_faces;
    cmax = {1'b0, {(COORD_W-1){1'b1}}};
    cmin = {1'b1, {(COORD_W-1){1'b0}}};
    all_faces = '1;

    // air and fully hidden voxels emit nothing
    pending_voxels.push_back(make_voxel(3, 4, 5, KIND_AIR, all_faces, 1'b0));
    pending_voxels.push_back(make_voxel(3, 4, 5, KIND_AIR, '0, 1'b0));
    pending_voxels.push_back(make_voxel(-2, 7, 1, KIND_GRASS, '0, 1'b0));
    // one face at a time, every kind
    for (int f = 0; f < 6; f++) begin
      pending_voxels.push_back(make_voxel(coord_t'(f), -1, 10, kind_t'(f % 3 + 1),
                                          face_mask_t'(1) << f, 1'b0));
    end
    pending_voxels.push_back(make_voxel(0, 0, 0, KIND_GRASS, all_faces, 1'b0));
    pending_voxels.push_back(make_voxel(1, 2, 3, KIND_DIRT, all_faces, 1'b0));
    pending_voxels.push_back(make_voxel(-5, -6, -7, KIND_STONE, all_faces, 1'b0));
    // coordinates at the range edges, top corner must not wrap
    pending_voxels.push_back(make_voxel(cmax, cmax, cmax, KIND_STONE, all_faces, 1'b0));
    pending_voxels.push_back(make_voxel(cmin, cmin, cmin, KIND_GRASS, all_faces, 1'b0));
    pending_voxels.push_back(make_voxel(cmax, cmin, -1, KIND_DIRT, 6'b010101, 1'b0));
    pending_voxels.push_back(make_voxel(-1, cmax, cmin, KIND_STONE, 6'b101010, 1'b0));
    pending_voxels.push_back(make_voxel(cmin, -1, cmax, KIND_GRASS, 6'b100001, 1'b0));
    pending_voxels.push_back(make_voxel(cmax, cmax, cmax, KIND_AIR, all_faces, 1'b0));

    useful = 0;
    while (pending_voxels.size() < TOTAL_VOXELS) begin
      vox.x = pick_coord();
      vox.y = pick_coord();
      vox.z = pick_coord();
      vox.kind = ($urandom_range(0, 9) == 0) ? KIND_AIR : kind_t'($urandom_range(1, 3));
      vox.mask = ($urandom_range(0, 9) == 0) ? face_mask_t'(0)
                                             : face_mask_t'($urandom_range(1, 63));
      // now and then hold back until the output side has drained
      vox.drain_first = (useful % 40 == 0);
      pending_voxels.push_back(vox);
      if (vox.kind != KIND_AIR && vox.mask != 0) begin
        useful++;
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_voxels.size() > 0 || in_valid) @(posedge clk);
    while (expected_vertices.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
